@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the range normalizer RTL
// Clocked checks on clk_i, optionally gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check that is masked while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check that also holds during reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hdl/rrn_pkg.sv @@
// ----------------------------------------------------------------------------
// rrn_pkg
// Shared types and codes of the running range normalizer.
// ----------------------------------------------------------------------------
package rrn_pkg;

  // width of the status code carried with each result item
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NORMAL     = 2'd0,
    STATUS_SEEDED     = 2'd1,
    STATUS_ZERO_RANGE = 2'd2
  } status_e;

endpackage

@@ hdl/rrn_if.sv @@
// ----------------------------------------------------------------------------
// rrn_sample_if / rrn_result_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface rrn_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rrn_result_if #(
  parameter int unsigned FRACTION_BITS = 16
) ();
  import rrn_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FRACTION_BITS:0] ratio;
  status_e                status;

  modport source (output valid, output ratio, output status, input ready);
  modport sink   (input valid, input ratio, input status, output ready);
endinterface

@@ hdl/rrn_front.sv @@
// ----------------------------------------------------------------------------
// rrn_front
// Accepts samples, tracks the running limits and classifies each item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrn_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata_i,
  rrn_sample_if.sink             smp_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output logic [rrn_pkg::STATUS_W+2*(SAMPLE_BITS+2)-1:0] q_data_o
);
  import rrn_pkg::*;

  localparam int unsigned LW = SAMPLE_BITS + 2;

  logic [SAMPLE_BITS-1:0] width_q;
  logic                   has_q, has_d;
  logic signed [LW-1:0]   low_q, low_d, high_q, high_d;

  logic signed [LW-1:0]   s_ext, half, w_ext, new_low, new_high, span, diff;
  status_e                cls;
  logic                   accept;

  assign smp_i.ready = !q_full_i;
  assign accept      = smp_i.valid && !q_full_i;

  assign s_ext = {{2{smp_i.sample[SAMPLE_BITS-1]}}, smp_i.sample};
  assign half  = {3'b000, width_q[SAMPLE_BITS-1:1]};
  assign w_ext = {2'b00, width_q};

  // widen first, then measure
  assign new_low  = (s_ext < low_q)  ? s_ext : low_q;
  assign new_high = (s_ext > high_q) ? s_ext : high_q;
  assign span     = new_high - new_low;
  assign diff     = s_ext - new_low;

  always_comb begin
    has_d  = has_q;
    low_d  = low_q;
    high_d = high_q;
    cls    = STATUS_NORMAL;
    if (!has_q) begin
      cls    = STATUS_SEEDED;
      has_d  = 1'b1;
      low_d  = s_ext - half;
      high_d = s_ext + (w_ext - half);
    end else begin
      low_d  = new_low;
      high_d = new_high;
      if (span[LW-1] || (span == '0)) begin
        cls = STATUS_ZERO_RANGE;
      end
    end
  end

  assign q_push_o = accept;
  assign q_data_o = {cls, diff, span};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q  <= 1'b0;
      low_q  <= '0;
      high_q <= '0;
    end else if (accept) begin
      has_q  <= has_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  `ASSERT_CLK(a_limits_ordered, has_q |-> (high_q >= low_q), "limits out of order")

endmodule

@@ hdl/rrn_queue.sv @@
// ----------------------------------------------------------------------------
// rrn_queue
// Two-entry FIFO between the classifier and the divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrn_queue #(
  parameter int unsigned DATA_W = 38
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);
  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count overflow")

endmodule

@@ hdl/rrn_back.sv @@
// ----------------------------------------------------------------------------
// rrn_back
// Restoring divider and output register for the normalized ratio.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrn_back #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  logic [rrn_pkg::STATUS_W+2*(SAMPLE_BITS+2)-1:0] q_data_i,
  output logic q_pop_o,
  rrn_result_if.source res_o
);
  import rrn_pkg::*;

  localparam int unsigned LW    = SAMPLE_BITS + 2;
  localparam int unsigned RW    = SAMPLE_BITS + 3;
  localparam int unsigned DW    = STATUS_W + 2 * LW;
  localparam int unsigned QW    = FRACTION_BITS + 1;
  localparam int unsigned CNT_W = $clog2(FRACTION_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [LW-1:0]    range_q, range_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [QW-1:0]    ratio_q, ratio_d;
  status_e          status_q, status_d;

  status_e          head_status;
  logic [LW-1:0]    head_diff, head_range;
  logic [RW-1:0]    range_ext, rem_sub;
  logic             ge, slot_free;

  assign head_status = status_e'(q_data_i[DW-1 -: STATUS_W]);
  assign head_diff   = q_data_i[2*LW-1 -: LW];
  assign head_range  = q_data_i[LW-1:0];

  // one quotient bit per cycle
  assign range_ext = {1'b0, range_q};
  assign ge        = (rem_q >= range_ext);
  assign rem_sub   = ge ? (rem_q - range_ext) : rem_q;

  assign slot_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    range_d     = range_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !res_o.ready;
    ratio_d     = ratio_q;
    status_d    = status_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i && slot_free) begin
          q_pop_o = 1'b1;
          unique case (head_status) inside
            STATUS_NORMAL: begin
              rem_d   = {1'b0, head_diff};
              range_d = head_range;
              quo_d   = '0;
              cnt_d   = CNT_W'(FRACTION_BITS);
              state_d = S_DIV;
            end
            STATUS_SEEDED, STATUS_ZERO_RANGE: begin
              out_valid_d = 1'b1;
              ratio_d     = '0;
              status_d    = head_status;
            end
            default: begin
              out_valid_d = 1'b1;
              ratio_d     = '0;
              status_d    = STATUS_ZERO_RANGE;
            end
          endcase
        end
      end
      S_DIV: begin
        quo_d = {quo_q[QW-2:0], ge};
        rem_d = {rem_sub[RW-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          ratio_d     = quo_q;
          status_d    = STATUS_NORMAL;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    range_q  <= range_d;
    quo_q    <= quo_d;
    ratio_q  <= ratio_d;
    status_q <= status_d;
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.ratio  = ratio_q;
  assign res_o.status = status_q;

  `ASSERT_CLK(a_pop_idle, q_pop_o |-> (state_q == S_IDLE), "pop outside idle")
  `ASSERT_CLK(a_div_range, (state_q == S_DIV) |-> (range_q != '0), "divide by zero range")
  `ASSERT_CLK(a_rem_bound, (state_q == S_DIV) |-> (rem_q < {range_ext[RW-2:0], 1'b0}),
              "remainder out of bound")
  `ASSERT_CLK(a_ratio_max, out_valid_q |-> (ratio_q <= {1'b1, {FRACTION_BITS{1'b0}}}),
              "ratio above one")
  `ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_q, "result valid during reset")

endmodule

@@ hdl/running_range_normalizer.sv @@
// ----------------------------------------------------------------------------
// running_range_normalizer
// Normalizes signed samples against running low/high limits, Q1.F result.
// ----------------------------------------------------------------------------
// Usage:
//   smp_i  : valid/ready channel, one signed sample per item.
//   res_o  : valid/ready channel, one result item (ratio, status) per sample.
//   cfg_we_i / cfg_wdata_i : writes the seed span placed around the first
//   sample; write only while idle.
// The first sample after reset seeds the limits around itself and returns
// ratio 0 with status SEEDED. Later samples widen the limits, then get
// (sample - low) / (high - low) as Q1.FRACTION_BITS, truncated.
// A taken sample is written to the queue; the back end pops it and puts a
// seeding or zero-range item straight into the output register, while a
// normal item first runs the restoring divider (S_DIV, then S_FIN).
// The divider makes one quotient bit per cycle and takes no new item until
// its result is in the output register; seeding and zero-range items pass
// at one per cycle while the receiver is ready.
// A two-entry queue sits between the classifier and the divider, so new
// samples are taken while a division runs or a result waits. When the
// receiver stalls, the result holds in the output register, the queue
// fills, and smp_i.ready drops. Reset clears the limits, the seed span
// and all pending items.
// ----------------------------------------------------------------------------
module running_range_normalizer #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata_i,
  rrn_sample_if.sink             smp_i,
  rrn_result_if.source           res_o
);
  import rrn_pkg::*;

  // queue entry: class code, numerator offset, range
  localparam int unsigned DW = STATUS_W + 2 * (SAMPLE_BITS + 2);

  logic          q_push, q_full, q_pop, q_empty;
  logic [DW-1:0] q_wdata, q_rdata;

  // front end: limit tracking and classification
  rrn_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_i       (smp_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // decoupling queue
  rrn_queue #(
    .DATA_W (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  // back end: divider and output register
  rrn_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

@@ tb/sv/running_range_normalizer_tb.sv @@
// ----------------------------------------------------------------------------
// running_range_normalizer_tb
// Self-checking bench for the running range normalizer. Drives signed
// samples through the valid/ready channels under several pacing phases.
// Each result item is checked against an in-bench predictor of the limits
// and the truncated Q1.16 quotient.
// ----------------------------------------------------------------------------
module running_range_normalizer_tb;
  import rrn_pkg::*;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned FRACTION_BITS = 16;
  // limits carry two extra bits so a seeded span never wraps
  localparam int unsigned LIMIT_BITS    = SAMPLE_BITS + 2;
  // worst-case item latency through the divider
  localparam int unsigned LATENCY       = FRACTION_BITS + 3;
  localparam int unsigned PHASE_ITEMS   = 420;
  localparam int unsigned N_PHASES      = 4;
  localparam int unsigned N_DIRECTED    = 16;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS-1:0]        width_t;
  typedef logic [FRACTION_BITS:0]        ratio_t;

  typedef struct {
    ratio_t  ratio;
    status_e status;
  } norm_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the running limits and queues the expected results.
  // --------------------------------------------------------------------------
  class range_scoreboard;
    width_t                       start_width = '0;
    bit                           has_limits  = 1'b0;
    logic signed [LIMIT_BITS-1:0] low_lim     = '0;
    logic signed [LIMIT_BITS-1:0] high_lim    = '0;
    norm_result_t                 pending[$];
    int unsigned                  n_mismatch  = 0;
    int unsigned                  n_results   = 0;
    int unsigned                  n_seeded    = 0;
    int unsigned                  n_zero      = 0;
    int unsigned                  n_normal    = 0;

    // accepted sample: update limits, queue what the block must return
    function void note_sample(sample_t s);
      longint           x;
      longint           half;
      longint           span;
      longint unsigned  num;
      longint unsigned  quot;
      norm_result_t     r;
      x = longint'(s);
      if (!has_limits) begin
        // seeding: span of exactly start_width, lower half rounded down
        half       = longint'(start_width >> 1);
        low_lim    = LIMIT_BITS'(x - half);
        high_lim   = LIMIT_BITS'(x + longint'(start_width) - half);
        has_limits = 1'b1;
        r.ratio    = '0;
        r.status   = STATUS_SEEDED;
        n_seeded++;
      end else begin
        if (x < longint'(low_lim))  low_lim  = LIMIT_BITS'(x);
        if (x > longint'(high_lim)) high_lim = LIMIT_BITS'(x);
        span = longint'(high_lim) - longint'(low_lim);
        if (span <= 0) begin
          r.ratio  = '0;
          r.status = STATUS_ZERO_RANGE;
          n_zero++;
        end else begin
          // truncating quotient, sample is inside the limits so no clamp
          num      = x - longint'(low_lim);
          num      = num << FRACTION_BITS;
          quot     = num / span;
          r.ratio  = ratio_t'(quot);
          r.status = STATUS_NORMAL;
          n_normal++;
        end
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(ratio_t ratio, status_e status);
      norm_result_t exp_r;
      n_results++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: ratio=%0d status=%0d",
                                  ratio, status));
        return;
      end
      exp_r = pending.pop_front();
      if (ratio !== exp_r.ratio)
        report_mismatch($sformatf("ratio got %0d want %0d", ratio, exp_r.ratio));
      if (status !== exp_r.status)
        report_mismatch($sformatf("status got %0d want %0d", status, exp_r.status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  width_t cfg_wdata_i;

  rrn_sample_if #(.SAMPLE_BITS(SAMPLE_BITS))     smp_if ();
  rrn_result_if #(.FRACTION_BITS(FRACTION_BITS)) res_if ();

  running_range_normalizer #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .smp_i      (smp_if),
    .res_o      (res_if)
  );

  range_scoreboard sb = new;

  // idle/stall odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_items        = 0;

  // directed samples; the first seeds the limits with a zero span, the next
  // two repeat it (zero range), then the extremes open the range fully
  sample_t directed_samples [N_DIRECTED] = '{
    16'sh0064, 16'sh0064, 16'sh0064, 16'sh8000,
    16'sh0064, 16'sh7FFF, 16'sh0000, 16'shFFFF,
    16'sh0001, 16'sh8000, 16'sh7FFF, 16'sh5555,
    16'shAAAA, 16'sh8001, 16'sh7FFE, 16'sh00FF
  };

  // register value written ahead of each random phase; extremes first
  width_t phase_width [N_PHASES];
  int unsigned phase_send_idle  [N_PHASES] = '{0, 88, 0, 32};
  int unsigned phase_recv_stall [N_PHASES] = '{0, 0, 88, 32};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on run time, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("timeout waiting on the block");
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random backpressure, and a check on every accepted item
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.ratio, res_if.status);
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------

  // mostly full-scale random, with clusters near both limits and near zero
  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15)      return sample_t'(32'h8000 + $urandom_range(15));
    else if (pick < 30) return sample_t'(32'h7FFF - $urandom_range(15));
    else if (pick < 40) return sample_t'(32'd8 - $urandom_range(16));
    else                return sample_t'($urandom);
  endfunction

  // one item: optional idle gap, then hold valid until accepted
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    sb.note_sample(s);
    n_items++;
  endtask

  // block is idle once every result is back and the divider has drained
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_start_width(input width_t w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.start_width = w;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    smp_if.valid  <= 1'b0;
    smp_if.sample <= '0;
    rst_ni        <= 1'b0;
    phase_width[0] = '1;
    phase_width[1] = '0;
    phase_width[2] = width_t'($urandom);
    phase_width[3] = width_t'(1);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero starting span, so repeats of the seed sample give a zero range;
    // later writes are taken but no longer move the seeded limits
    write_start_width('0);
    foreach (directed_samples[i]) send_sample(directed_samples[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_start_width(phase_width[ph]);
      send_idle_pct  <= phase_send_idle[ph];
      recv_stall_pct <= phase_recv_stall[ph];
      @(posedge clk_i);
      repeat (PHASE_ITEMS) send_sample(rand_sample());
    end

    smp_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);

    $display("Sent %0d samples over %0d pacing phases (free, sender gaps, stalls, both).",
             n_items, N_PHASES);
    $display("Checked %0d results: %0d seeding, %0d zero range, %0d normal; %0d mismatches.",
             sb.n_results, sb.n_seeded, sb.n_zero, sb.n_normal, sb.n_mismatch);
    if (sb.n_mismatch == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
